// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
// Each helper takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LFR_ASSERT_SAME(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("lfr assertion failed");

// Next-cycle implication.
`define LFR_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("lfr assertion failed");

`endif

// ===== design/lfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants of the LRU frame replacer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfr_pkg;

	localparam int NUM_FRAMES = 64;
	localparam int IDX_W      = $clog2(NUM_FRAMES);
	localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
	localparam int OP_W       = 2;
	localparam int FRAME_W    = 6;
	localparam int TCNT_W     = 7;
	localparam int CAP_W      = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_VICTIM = 2'd0,
		OP_PIN    = 2'd1,
		OP_UNPIN  = 2'd2
	} op_t;

	// Command from the control path to the order list.
	typedef struct packed {
		logic               pop_head;  // drop entry 0, shift everything down
		logic               remove;    // drop the entry equal to frame
		logic               ins;       // write frame at ins_pos
		logic [IDX_W-1:0]   ins_pos;
		logic [FRAME_W-1:0] frame;
	} list_cmd_t;

endpackage

`default_nettype wire

// ===== design/lfr_if.sv =====
// ----------------------------------------------------------------------------
// lfr_if
// Valid/ready channels of the LRU frame replacer: request, result, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lfr_req_if;
	logic                        valid;
	logic                        ready;
	logic [lfr_pkg::OP_W-1:0]    operation;
	logic [lfr_pkg::FRAME_W-1:0] frame_number;

	modport source (output valid, operation, frame_number, input ready);
	modport sink   (input valid, operation, frame_number, output ready);
endinterface

interface lfr_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        victim_found;
	logic [lfr_pkg::FRAME_W-1:0] victim_frame;
	logic [lfr_pkg::TCNT_W-1:0]  tracked_count;

	modport source (output valid, victim_found, victim_frame, tracked_count, input ready);
	modport sink   (input valid, victim_found, victim_frame, tracked_count, output ready);
endinterface

interface lfr_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [lfr_pkg::CAP_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/lfr_order_list.sv =====
// ----------------------------------------------------------------------------
// lfr_order_list
// Compacting age-ordered frame list, oldest at entry 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfr_order_list (
	input  wire                         clk,
	input  wire                         apply,
	input  lfr_pkg::list_cmd_t          cmd,
	output logic [lfr_pkg::FRAME_W-1:0] head
);

	localparam int N   = lfr_pkg::NUM_FRAMES;
	localparam int LVL = $clog2(N);

	logic [lfr_pkg::FRAME_W-1:0] entry_q [N];
	logic [N-1:0]                pre [LVL+1];
	logic [N-1:0]                shift;

	assign head = entry_q[0];

	// Entries from the matching one upward shift down: prefix OR of the
	// match vector, log-depth. Stale matches above the count sit past the
	// real match, so they do not change the mask.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			pre[0][i] = (entry_q[i] == cmd.frame);
		end
		for (int l = 0; l < LVL; l++) begin
			for (int i = 0; i < N; i++) begin
				if (i >= (1 << l)) begin
					pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
				end else begin
					pre[l+1][i] = pre[l][i];
				end
			end
		end
		if (cmd.pop_head) begin
			shift = '1;
		end else if (cmd.remove) begin
			shift = pre[LVL];
		end else begin
			shift = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			for (int i = 0; i < N - 1; i++) begin
				if (shift[i]) begin
					entry_q[i] <= entry_q[i+1];
				end
			end
			if (cmd.ins) begin
				entry_q[cmd.ins_pos] <= cmd.frame;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/lru_frame_replacer_unit.sv =====
// ----------------------------------------------------------------------------
// lru_frame_replacer_unit
// LRU frame replacer: victim, pin and unpin on an age-ordered frame list.
// ----------------------------------------------------------------------------
// Path: an accepted request is captured in the input register, then one pass
//   of update logic writes its result into the result register.
// Throughput: one item per cycle while the result register is not stalled.
// Reset: tracked count zero, all tracked bits clear, capacity_limit 64.
//   List contents are left undefined; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_frame_replacer_unit (
	input  wire        clk,
	input  wire        arst_n,
	lfr_req_if.sink    req,
	lfr_rsp_if.source  rsp,
	lfr_cfg_if.sink    cfg
);

	// Config register: always ready; written only while idle is a rule for the user, not enforced by the block.
	logic [lfr_pkg::CAP_W-1:0] cap_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfr_pkg::CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.data;
		end
	end

	// Input register
	logic                        valid_s1;
	logic [lfr_pkg::OP_W-1:0]    op_s1;
	logic [lfr_pkg::FRAME_W-1:0] frame_s1;

	// Result register
	logic                        valid_s2;
	logic                        found_s2;
	logic [lfr_pkg::FRAME_W-1:0] vframe_s2;
	logic [lfr_pkg::CNT_W-1:0]   count_s2;

	// Tracker state
	logic [lfr_pkg::CNT_W-1:0]      count_q;
	logic [lfr_pkg::NUM_FRAMES-1:0] tracked_q;

	logic advance;

	// Stage 1 moves on whenever the result register is free or being drained.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1    <= req.operation;
			frame_s1 <= req.frame_number;
		end
	end

	// Update logic for the item in stage 1
	lfr_pkg::list_cmd_t          cmd;
	logic [lfr_pkg::FRAME_W-1:0] head;
	logic [lfr_pkg::IDX_W-1:0]   fidx;
	logic [lfr_pkg::IDX_W-1:0]   hidx;
	logic                        frame_ok;
	logic                        found;
	logic [lfr_pkg::FRAME_W-1:0] vframe;
	logic [lfr_pkg::CNT_W-1:0]   count_next;
	logic                        clr_en;
	logic [lfr_pkg::IDX_W-1:0]   clr_idx;
	logic                        set_en;

	assign fidx     = lfr_pkg::IDX_W'(frame_s1);
	assign hidx     = lfr_pkg::IDX_W'(head);
	assign frame_ok = (32'(frame_s1) < lfr_pkg::NUM_FRAMES);

	always_comb begin
		cmd         = '0;
		cmd.frame   = frame_s1;
		cmd.ins_pos = count_q[lfr_pkg::IDX_W-1:0];
		found       = 1'b0;
		vframe      = '0;
		count_next  = count_q;
		clr_en      = 1'b0;
		clr_idx     = fidx;
		set_en      = 1'b0;
		unique case (op_s1)
			lfr_pkg::OP_VICTIM: begin
				if (count_q != '0) begin
					cmd.pop_head = 1'b1;
					found        = 1'b1;
					vframe       = head;
					count_next   = count_q - lfr_pkg::CNT_W'(1);
					clr_en       = 1'b1;
					clr_idx      = hidx;
				end
			end
			lfr_pkg::OP_PIN: begin
				if (frame_ok && tracked_q[fidx]) begin
					cmd.remove = 1'b1;
					count_next = count_q - lfr_pkg::CNT_W'(1);
					clr_en     = 1'b1;
				end
			end
			lfr_pkg::OP_UNPIN: begin
				// Already tracked: keep its age. Full or at capacity: ignored.
				if (frame_ok && !tracked_q[fidx] &&
				    32'(count_q) < 32'(cap_q) &&
				    32'(count_q) < lfr_pkg::NUM_FRAMES) begin
					cmd.ins    = 1'b1;
					count_next = count_q + lfr_pkg::CNT_W'(1);
					set_en     = 1'b1;
				end
			end
			default: begin
				// Unused code: no effect.
			end
		endcase
	end

	lfr_order_list u_list (
		.clk   (clk),
		.apply (advance),
		.cmd   (cmd),
		.head  (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			tracked_q <= '0;
		end else if (advance) begin
			count_q <= count_next;
			if (clr_en) begin
				tracked_q[clr_idx] <= 1'b0;
			end
			if (set_en) begin
				tracked_q[fidx] <= 1'b1;
			end
		end
	end

	// Result register: holds until taken; stage 1 moves into it only as it is freed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_s2  <= found;
			vframe_s2 <= vframe;
			count_s2  <= count_next;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.victim_found  = found_s2;
	assign rsp.victim_frame  = vframe_s2;
	assign rsp.tracked_count = lfr_pkg::TCNT_W'(count_s2);

endmodule

`default_nettype wire

// ===== design/lfr_checker.sv =====
// ----------------------------------------------------------------------------
// lfr_checker
// Port-level assertions for the LRU frame replacer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lfr_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         rsp_valid,
	input wire                         rsp_ready,
	input wire                         rsp_found,
	input wire [lfr_pkg::FRAME_W-1:0]  rsp_frame,
	input wire [lfr_pkg::TCNT_W-1:0]   rsp_count
);

	// Stalled result stays offered.
	`LFR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// Count never exceeds the number of frames.
	`LFR_ASSERT_SAME(a_count_max, clk, arst_n, rsp_valid, 32'(rsp_count) <= lfr_pkg::NUM_FRAMES)

	// No victim: frame field is zero.
	`LFR_ASSERT_SAME(a_frame_zero, clk, arst_n, rsp_valid && !rsp_found, rsp_frame == '0)

	// A victim was removed, so the list cannot still be full.
	`LFR_ASSERT_SAME(a_victim_count, clk, arst_n, rsp_valid && rsp_found, 32'(rsp_count) < lfr_pkg::NUM_FRAMES)

endmodule

bind lru_frame_replacer_unit lfr_checker u_lfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_found (rsp.victim_found),
	.rsp_frame (rsp.victim_frame),
	.rsp_count (rsp.tracked_count)
);

`default_nettype wire

// ===== tb/sv/lfr_replacer_checker.sv =====
// ----------------------------------------------------------------------------
// lfr_replacer_checker
// Watches the request, result and config channels of the LRU frame replacer,
// keeps its own age-ordered frame list and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfr_replacer_checker (
	input  wire clk,
	input  wire arst_n,
	lfr_req_if  req,
	lfr_rsp_if  rsp,
	lfr_cfg_if  cfg,
	output int  fail_count,
	output int  pending_count
);
	import lfr_pkg::*;

	typedef struct packed {
		logic               victim_found;
		logic [FRAME_W-1:0] victim_frame;
		logic [TCNT_W-1:0]  tracked_count;
	} replacer_result_t;

	logic [FRAME_W-1:0]    age_order[$];   // oldest at the front
	logic [NUM_FRAMES-1:0] on_list;
	logic [CAP_W-1:0]      capacity;
	replacer_result_t      expected_q[$];
	int                    mismatches = 0;

	assign fail_count = mismatches;

	// Apply one operation to the shadow list, return the result it should give.
	function replacer_result_t apply_request(input logic [OP_W-1:0] op,
			input logic [FRAME_W-1:0] fr);
		replacer_result_t res;
		int pos;
		res = '0;
		pos = -1;
		case (op)
		OP_VICTIM: begin
			if (age_order.size() != 0) begin
				res.victim_frame = age_order[0];
				age_order.delete(0);
				res.victim_found = 1'b1;
				on_list[res.victim_frame] = 1'b0;
			end
		end
		OP_PIN: begin
			if (on_list[fr]) begin
				foreach (age_order[i])
					if (age_order[i] == fr)
						pos = i;
				if (pos >= 0)
					age_order.delete(pos);
				on_list[fr] = 1'b0;
			end
		end
		OP_UNPIN: begin
			// an already tracked frame keeps its age
			if (!on_list[fr] && age_order.size() < capacity &&
					age_order.size() < NUM_FRAMES) begin
				age_order.insert(age_order.size(), fr);
				on_list[fr] = 1'b1;
			end
		end
		default: ;
		endcase
		res.tracked_count = TCNT_W'(age_order.size());
		return res;
	endfunction

	function void check_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		replacer_result_t want;
		if (!arst_n) begin
			age_order.delete();
			expected_q.delete();
			on_list = '0;
			capacity = CAP_RESET;
			pending_count <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				capacity = cfg.data;
			if (req.valid && req.ready)
				expected_q.insert(expected_q.size(),
					apply_request(req.operation, req.frame_number));
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result item with none expected, actual %0d/%0d/%0d",
						$time, rsp.victim_found, rsp.victim_frame, rsp.tracked_count);
					mismatches++;
				end else begin
					want = expected_q[0];
					expected_q.delete(0);
					check_field("victim_found", want.victim_found, rsp.victim_found);
					check_field("victim_frame", want.victim_frame, rsp.victim_frame);
					check_field("tracked_count", want.tracked_count, rsp.tracked_count);
				end
			end
			pending_count <= expected_q.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the LRU frame replacer. A directed opening walks
// the special cases, then bursts of random and well-formed fill/drain
// sequences run under a range of capacity settings. Results are checked
// item by item by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import lfr_pkg::*;

	// Code 3 has no operation behind it; the block must treat it as a no-op.
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

	// Cycles without any handshake before the run is declared hung.
	localparam int IDLE_LIMIT   = 2000;
	// Quiet cycles after the last result so stray items can show up.
	localparam int DRAIN_CYCLES = 8;

	// Receiver stall modes.
	localparam logic [1:0] RX_OPEN = 2'd0;   // always ready
	localparam logic [1:0] RX_COIN = 2'd1;   // ready at random
	localparam logic [1:0] RX_COMB = 2'd2;   // not ready whenever stall_tick[2:0] is zero
	localparam logic [1:0] RX_LONG = 2'd3;   // long periodic stall

	logic       clk;
	logic       arst_n;
	int         fail_count;
	int         pending_count;
	int         burst_left;
	int         idle_cycles;
	logic [7:0] stall_tick;
	logic [1:0] stall_mode;

	lfr_req_if req();
	lfr_rsp_if rsp();
	lfr_cfg_if cfg();

	lru_frame_replacer_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	lfr_replacer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.cfg           (cfg),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Receiver: the stall mode is redrawn whenever the low seven bits of stall_tick wrap
	// to zero, so long open stretches alternate with random, periodic and long stalls.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 8'd1;
		if (stall_tick[6:0] == 7'd0)
			stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
		RX_OPEN: rsp.ready <= 1'b1;
		RX_COIN: rsp.ready <= 1'($urandom_range(0, 1));
		RX_COMB: rsp.ready <= (stall_tick[2:0] != 3'd0);
		default: rsp.ready <= (stall_tick[5:4] != 2'b00);
		endcase
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
				(cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[lru_frame_replacer_unit] ERROR");
			$finish;
		end
	end

	// Present one item and hold it until accepted. Items go out in bursts;
	// between bursts valid drops for a random gap. About one burst in four
	// is long, which gives stretches with no sender idling at all.
	task automatic send(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] fr);
		if (burst_left == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
		end
		req.valid        <= 1'b1;
		req.operation    <= op;
		req.frame_number <= fr;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		burst_left--;
	endtask

	// Capacity is only changed with the block drained: stop sending, wait
	// for every outstanding result item, then write the register.
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data  <= cap;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Random mix. narrow_pct steers frames into 0..7 so pins and repeated
	// unpins hit tracked frames often; the rest spans the full range.
	task automatic random_items(input int count, input int unpin_pct, input int narrow_pct);
		int                 roll;
		logic [OP_W-1:0]    op;
		logic [FRAME_W-1:0] fr;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < unpin_pct)
				op = OP_UNPIN;
			else if (roll >= 95)
				op = OP_RESERVED;
			else if (roll[0])
				op = OP_PIN;
			else
				op = OP_VICTIM;
			if ($urandom_range(0, 99) < narrow_pct)
				fr = FRAME_W'($urandom_range(0, 7));
			else
				fr = FRAME_W'($urandom);
			send(op, fr);
		end
	endtask

	// Well-formed sequence: unpin every frame once in shuffled order, repeat
	// one already tracked, pin a few, then evict until (nearly) empty.
	task automatic fill_and_drain;
		logic [FRAME_W-1:0] deck[NUM_FRAMES];
		logic [FRAME_W-1:0] held;
		int                 i;
		int                 j;
		for (i = 0; i < NUM_FRAMES; i++)
			deck[i] = FRAME_W'(i);
		for (i = NUM_FRAMES - 1; i > 0; i--) begin
			j       = $urandom_range(0, i);
			held    = deck[i];
			deck[i] = deck[j];
			deck[j] = held;
		end
		foreach (deck[k])
			send(OP_UNPIN, deck[k]);
		send(OP_UNPIN, deck[$urandom_range(0, NUM_FRAMES - 1)]);
		repeat (6)
			send(OP_PIN, FRAME_W'($urandom));
		repeat (62)
			send(OP_VICTIM, FRAME_W'($urandom));
	endtask

	initial begin
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.operation    = OP_VICTIM;
		req.frame_number = '0;
		cfg.valid        = 1'b0;
		cfg.data         = '0;
		rsp.ready        = 1'b0;
		stall_tick       = '0;
		stall_mode       = RX_OPEN;
		idle_cycles      = 0;
		burst_left       = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, capacity at its reset value.
		send(OP_VICTIM, 6'd63);     // empty list; frame field ignored
		send(OP_RESERVED, 6'd0);    // unused code does nothing
		send(OP_PIN, 6'd5);         // pin of an untracked frame
		send(OP_UNPIN, 6'd0);
		send(OP_UNPIN, 6'd63);
		send(OP_UNPIN, 6'd0);       // already tracked: age kept
		send(OP_UNPIN, 6'd21);
		send(OP_UNPIN, 6'd42);
		send(OP_PIN, 6'd63);        // removal from the middle
		send(OP_PIN, 6'd0);         // removal at the head
		send(OP_UNPIN, 6'd0);       // back in as newest
		send(OP_VICTIM, 6'd7);      // expect 21
		send(OP_RESERVED, 6'd63);
		send(OP_VICTIM, 6'd0);      // expect 42
		send(OP_UNPIN, 6'd42);
		send(OP_VICTIM, 6'd0);      // expect 0
		send(OP_VICTIM, 6'd0);      // expect 42
		send(OP_VICTIM, 6'd0);      // empty again
		send(OP_PIN, 6'd42);

		// Capacity above the frame count: the list tops out at 64 entries.
		set_capacity(7'd127);
		fill_and_drain();
		random_items(60, 60, 30);

		// One short of full: the last distinct unpin is refused.
		set_capacity(7'd63);
		fill_and_drain();

		// Small capacities keep the list short and often at its limit.
		set_capacity(7'd0);
		random_items(40, 60, 50);
		set_capacity(7'd1);
		random_items(60, 55, 50);
		set_capacity(7'd2);
		random_items(60, 55, 50);

		set_capacity(7'd64);
		random_items(80, 60, 20);
		set_capacity(7'($urandom_range(3, 62)));
		random_items(100, 55, 40);

		// Drain and give stray result items a chance to appear.
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[lru_frame_replacer_unit] OK");
		else
			$display("[lru_frame_replacer_unit] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/lfr_pkg.sv
design/lfr_if.sv
design/lfr_order_list.sv
design/lru_frame_replacer_unit.sv
design/lfr_checker.sv
tb/sv/lfr_replacer_checker.sv
tb/sv/testbench.sv
